// File: design/fdsg_pkg.sv
// Shared widths, constants and beat type of the filled disc span generator.
package fdsg_pkg;

    // Field widths fixed by the interface.
    localparam int X_W         = 14;  // centre coordinates, signed Q4
    localparam int COLOR_W     = 8;
    localparam int RAD_W       = 5;
    localparam int ROW_OUT_W   = 8;
    localparam int COL_OUT_W   = 9;

    // Internal arithmetic widths.
    // Row offsets stay within +/-(r*16 + 32), r <= 31.
    localparam int DY_W        = 11;            // signed row offset, Q4
    localparam int MAG_W       = 10;            // |first row offset|
    localparam int ACC_W       = 21;            // signed r^2 - dy^2, Q8
    localparam int ROOT_W      = 9;             // half-width, Q4
    localparam int SQ_W        = 2 * ROOT_W;    // root unit operand

    localparam logic [RAD_W-1:0] RADIUS_RESET = 5'd10;

    typedef struct packed {
        logic [ROW_OUT_W-1:0] row;
        logic [COL_OUT_W-1:0] left_x;
        logic [COL_OUT_W-1:0] right_x;
        logic [COLOR_W-1:0]   span_color;
        logic                 visible;
        logic                 last;
    } t_out_beat;

endpackage

// File: design/fdsg_if.sv
// Channel interfaces: disc input, span output and radius write.
interface fdsg_in_if;
    import fdsg_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [X_W-1:0]   center_x_q4;
    logic signed [X_W-1:0]   center_y_q4;
    logic [COLOR_W-1:0]      color;

    modport source (output valid, output center_x_q4, output center_y_q4,
                    output color, input ready);
    modport sink   (input valid, input center_x_q4, input center_y_q4,
                    input color, output ready);
endinterface

interface fdsg_out_if;
    import fdsg_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [ROW_OUT_W-1:0]    row;
    logic [COL_OUT_W-1:0]    left_x;
    logic [COL_OUT_W-1:0]    right_x;
    logic [COLOR_W-1:0]      span_color;
    logic                    visible;
    logic                    last;

    modport source (output valid, output row, output left_x, output right_x,
                    output span_color, output visible, output last, input ready);
    modport sink   (input valid, input row, input left_x, input right_x,
                    input span_color, input visible, input last, output ready);
endinterface

interface fdsg_cfg_if;
    import fdsg_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [RAD_W-1:0]        radius;

    modport source (output valid, output radius, input ready);
    modport sink   (input valid, input radius, output ready);
endinterface

// File: design/fdsg_isqrt.sv
// Digit-serial integer square root, two operand bits per cycle.
module fdsg_isqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [fdsg_pkg::SQ_W-1:0]     i_n,
    output logic                          o_done,
    output logic [fdsg_pkg::ROOT_W-1:0]   o_root
);
    import fdsg_pkg::*;

    localparam int REM_W = ROOT_W + 1;
    localparam int CNT_W = $clog2(ROOT_W);

    logic [SQ_W-1:0]   r_n;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_q;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [REM_W+1:0]  w_rem_sh;
    logic [REM_W+1:0]  w_trial;
    logic [REM_W+2:0]  w_diff;
    logic              w_ge;

    // trial = 4q + 1
    assign w_rem_sh = {r_rem, r_n[SQ_W-1 -: 2]};
    assign w_trial  = {1'b0, r_q, 2'b01};
    assign w_diff   = {1'b0, w_rem_sh} - {1'b0, w_trial};
    assign w_ge     = !w_diff[REM_W+2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNT_W'(ROOT_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= i_n;
            r_rem <= '0;
            r_q   <= '0;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_n   <= {r_n[SQ_W-3:0], 2'b00};
            r_rem <= w_ge ? w_diff[REM_W-1:0] : w_rem_sh[REM_W-1:0];
            r_q   <= {r_q[ROOT_W-2:0], w_ge};
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    assign o_done = r_done;
    assign o_root = r_q;

endmodule

// File: design/filled_disc_span_generator_core.sv
// Top level: filled disc rasterizer emitting one horizontal span per covered row.
//
// Usage:
//   i_cfg  writes the disc radius in whole pixels (reset value 10). Write it only
//          while the block is idle; the channel is always ready.
//   i_in   takes one disc per beat: centre x/y in signed Q4 and a palette index.
//          Ready is high only between discs.
//   o_out  gives the spans top to bottom, one beat per covered row; last marks
//          the final beat of a disc. A disc that covers nothing gives a single
//          beat with visible = 0, last = 1 and all other fields zero.
// Steps per disc:
//   setup, then a shift-add square of the first row offset (one multiplier
//   bit per cycle), then per row a test: a row that misses the disc goes on
//   to the next row, and a covered row waits for the 9-step two-bit-per-cycle
//   root unit. Each span goes out only once the next one is found, since the
//   last flag needs the next covered row (or the end of the disc) to be known.
// Stall: a span waits in the output register; the block stalls in its span
// step only while the lookahead slot holds data and that register holds a
// beat not yet taken, and in its flush step while that register holds a beat
// not yet taken. Reset empties the output register and sets the radius to 10.
module filled_disc_span_generator_core #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 240
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    fdsg_in_if.sink         i_in,
    fdsg_out_if.source      o_out,
    fdsg_cfg_if.sink        i_cfg
);
    import fdsg_pkg::*;

    localparam int RW = $clog2(SCREEN_HEIGHT);   // internal row counter
    localparam int CW = $clog2(SCREEN_WIDTH);    // internal column
    localparam logic signed [11:0] LAST_ROW_S = 12'(SCREEN_HEIGHT - 1);
    localparam logic [10:0]        LAST_COL   = 11'(SCREEN_WIDTH - 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SETUP = 7'b0000010,
        S_MUL   = 7'b0000100,
        S_TEST  = 7'b0001000,
        S_ROOT  = 7'b0010000,
        S_SPAN  = 7'b0100000,
        S_FLUSH = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    logic [RAD_W-1:0]         r_radius;
    logic signed [X_W-1:0]    r_xq;
    logic signed [X_W-1:0]    r_yq;
    logic [COLOR_W-1:0]       r_color;

    logic [RW-1:0]            r_row, n_row;
    logic [RW-1:0]            r_lastrow, n_lastrow;
    logic signed [DY_W-1:0]   r_dy, n_dy;
    logic signed [ACC_W-1:0]  r_acc, n_acc;      // r^2 - dy^2 in Q8
    logic [ACC_W-2:0]         r_mc, n_mc;        // multiplicand, shifts up
    logic [MAG_W-1:0]         r_mp, n_mp;        // multiplier, shifts down
    logic [ROOT_W-1:0]        r_dq;

    // lookahead slot: the newest span, held until its last flag is known
    logic                     r_hold_v, n_hold_v;
    logic [RW-1:0]            r_hold_row, n_hold_row;
    logic [CW-1:0]            r_hold_left, n_hold_left;
    logic [CW-1:0]            r_hold_right, n_hold_right;

    logic                     r_ovalid;
    t_out_beat                r_out, n_out;
    logic                     w_out_load;

    logic                     w_in_acc;
    logic                     w_slot_free;
    logic                     w_step_row;
    logic                     w_sqrt_start;
    logic                     w_sqrt_done;
    logic [ROOT_W-1:0]        w_sqrt_root;

    // setup arithmetic
    logic [8:0]               w_r16;
    logic [17:0]              w_r2q8;
    logic signed [14:0]       w_vlo, w_vhi;
    logic [14:0]              w_vhi_abs;
    logic [10:0]              w_hi_mag;
    logic signed [11:0]       w_first, w_thi, w_lastr, w_lastc;
    logic                     w_empty;
    logic [X_W-1:0]           w_yq_abs;
    logic [MAG_W-1:0]         w_mag0;
    logic signed [DY_W-1:0]   w_dy0;

    // span arithmetic
    logic signed [14:0]       w_vl, w_vr;
    logic [10:0]              w_left_u, w_right_raw, w_right_u;
    logic                     w_span_vis;

    assign w_in_acc    = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_slot_free = !r_ovalid || o_out.ready;

    // ---- row range of the disc ----
    assign w_r16     = {r_radius, 4'b0000};
    assign w_r2q8    = {10'(r_radius * r_radius), 8'h00};
    assign w_vlo     = 15'(r_yq) - $signed({6'b0, w_r16});
    assign w_vhi     = 15'(r_yq) + $signed({6'b0, w_r16});
    assign w_first   = w_vlo[14] ? 12'sd0 : $signed({1'b0, w_vlo[14:4]});
    assign w_vhi_abs = w_vhi[14] ? 15'(-w_vhi) : w_vhi;
    assign w_hi_mag  = w_vhi_abs[14:4];
    // truncation toward zero
    assign w_thi     = w_vhi[14] ? -$signed({1'b0, w_hi_mag}) : $signed({1'b0, w_hi_mag});
    assign w_lastr   = w_thi + 12'sd1;
    assign w_lastc   = (w_lastr > LAST_ROW_S) ? LAST_ROW_S : w_lastr;
    assign w_empty   = w_first > w_lastc;

    // first row offset: floor case gives -(r16 + low nibble), clamped case -y
    assign w_yq_abs  = r_yq[X_W-1] ? X_W'(-r_yq) : r_yq;
    assign w_mag0    = w_vlo[14] ? w_yq_abs[MAG_W-1:0]
                                 : MAG_W'({1'b0, w_r16} + {6'b0, w_vlo[3:0]});
    assign w_dy0     = w_vlo[14] ? DY_W'(-r_yq) : -$signed({1'b0, w_mag0});

    // ---- span of the current row ----
    assign w_vl        = 15'(r_xq) - $signed({6'b0, r_dq});
    assign w_vr        = 15'(r_xq) + $signed({6'b0, r_dq});
    assign w_left_u    = w_vl[14] ? 11'd0 : w_vl[14:4];
    assign w_right_raw = w_vr[14] ? 11'd0 : w_vr[14:4];
    assign w_right_u   = (w_right_raw > LAST_COL) ? LAST_COL : w_right_raw;
    // right truncates below zero only from -16 down
    assign w_span_vis  = (w_vr >= -15'sd15) && (w_left_u <= w_right_u);

    fdsg_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sqrt_start),
        .i_n     (r_acc[SQ_W-1:0]),
        .o_done  (w_sqrt_done),
        .o_root  (w_sqrt_root)
    );

    always_comb begin
        n_state      = r_state;
        n_row        = r_row;
        n_lastrow    = r_lastrow;
        n_dy         = r_dy;
        n_acc        = r_acc;
        n_mc         = r_mc;
        n_mp         = r_mp;
        n_hold_v     = r_hold_v;
        n_hold_row   = r_hold_row;
        n_hold_left  = r_hold_left;
        n_hold_right = r_hold_right;
        n_out        = '0;
        w_out_load   = 1'b0;
        w_step_row   = 1'b0;
        w_sqrt_start = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) n_state = S_SETUP;
            end
            S_SETUP: begin
                if (w_empty) begin
                    n_state = S_FLUSH;
                end else begin
                    n_row     = w_first[RW-1:0];
                    n_lastrow = w_lastc[RW-1:0];
                    n_dy      = w_dy0;
                    n_acc     = ACC_W'($signed({1'b0, w_r2q8}));
                    n_mc      = (ACC_W-1)'(w_mag0);
                    n_mp      = w_mag0;
                    n_state   = S_MUL;
                end
            end
            S_MUL: begin
                // acc = r^2 - dy0^2, one multiplier bit per cycle
                if (r_mp[0]) n_acc = r_acc - $signed({1'b0, r_mc});
                n_mc = {r_mc[ACC_W-3:0], 1'b0};
                n_mp = r_mp >> 1;
                if (n_mp == '0) n_state = S_TEST;
            end
            S_TEST: begin
                if (!r_acc[ACC_W-1] && r_acc != '0) begin
                    w_sqrt_start = 1'b1;
                    n_state      = S_ROOT;
                end else begin
                    w_step_row = 1'b1;
                end
            end
            S_ROOT: begin
                if (w_sqrt_done) n_state = S_SPAN;
            end
            S_SPAN: begin
                if (!w_span_vis) begin
                    w_step_row = 1'b1;
                end else if (!r_hold_v || w_slot_free) begin
                    if (r_hold_v) begin
                        w_out_load       = 1'b1;
                        n_out.row        = ROW_OUT_W'(r_hold_row);
                        n_out.left_x     = COL_OUT_W'(r_hold_left);
                        n_out.right_x    = COL_OUT_W'(r_hold_right);
                        n_out.span_color = r_color;
                        n_out.visible    = 1'b1;
                        n_out.last       = 1'b0;
                    end
                    n_hold_v     = 1'b1;
                    n_hold_row   = r_row;
                    n_hold_left  = w_left_u[CW-1:0];
                    n_hold_right = w_right_u[CW-1:0];
                    w_step_row   = 1'b1;
                end
            end
            S_FLUSH: begin
                if (w_slot_free) begin
                    w_out_load = 1'b1;
                    n_out.last = 1'b1;
                    if (r_hold_v) begin
                        n_out.row        = ROW_OUT_W'(r_hold_row);
                        n_out.left_x     = COL_OUT_W'(r_hold_left);
                        n_out.right_x    = COL_OUT_W'(r_hold_right);
                        n_out.span_color = r_color;
                        n_out.visible    = 1'b1;
                    end
                    n_hold_v = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // next row: dy += 16, so dy^2 grows by 32*dy + 256
        if (w_step_row) begin
            if (r_row == r_lastrow) begin
                n_state = S_FLUSH;
            end else begin
                n_row   = r_row + RW'(1);
                n_dy    = r_dy + DY_W'(16);
                n_acc   = r_acc - (ACC_W'(r_dy) <<< 5) - ACC_W'(256);
                n_state = S_TEST;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_hold_v <= 1'b0;
            r_ovalid <= 1'b0;
            r_radius <= RADIUS_RESET;
        end else begin
            r_state  <= n_state;
            r_hold_v <= n_hold_v;
            if (w_out_load)       r_ovalid <= 1'b1;
            else if (o_out.ready) r_ovalid <= 1'b0;
            if (i_cfg.valid && i_cfg.ready) r_radius <= i_cfg.radius;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_xq    <= i_in.center_x_q4;
            r_yq    <= i_in.center_y_q4;
            r_color <= i_in.color;
        end
        if (w_sqrt_done) r_dq <= w_sqrt_root;
        if (w_out_load)  r_out <= n_out;
        r_row        <= n_row;
        r_lastrow    <= n_lastrow;
        r_dy         <= n_dy;
        r_acc        <= n_acc;
        r_mc         <= n_mc;
        r_mp         <= n_mp;
        r_hold_row   <= n_hold_row;
        r_hold_left  <= n_hold_left;
        r_hold_right <= n_hold_right;
    end

    assign o_out.valid      = r_ovalid;
    assign o_out.row        = r_out.row;
    assign o_out.left_x     = r_out.left_x;
    assign o_out.right_x    = r_out.right_x;
    assign o_out.span_color = r_out.span_color;
    assign o_out.visible    = r_out.visible;
    assign o_out.last       = r_out.last;

    // lookahead slot is drained before a new disc starts
    a_idle_no_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_hold_v)
        else $error("span left in lookahead slot between discs");

    // empty-disc marker is always the closing beat
    a_marker_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !r_out.visible) |-> r_out.last)
        else $error("invisible beat without last");

    // root unit only finishes while the sequencer waits for it
    a_root_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sqrt_done |-> (r_state == S_ROOT))
        else $error("root result outside root wait");

    // row walk never passes the final row
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TEST || r_state == S_ROOT || r_state == S_SPAN)
            |-> (r_row <= r_lastrow))
        else $error("row counter past final row");

    // a new span beat leaves only after the previous one was taken
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |-> (!r_ovalid || o_out.ready))
        else $error("output register overwritten while stalled");

endmodule
